[hdl/scts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scts_pkg
// Shared types and constants of the scope timing statistics block.
// ----------------------------------------------------------------------------
package scts_pkg;

    localparam int TABLE_DEPTH_DEF   = 64;
    localparam int MAX_IN_FLIGHT_DEF = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VALID_BITS    = 3'd0,
        REG_TICK_PERIOD   = 3'd1,
        REG_FRAMES_FLIGHT = 3'd2,
        REG_SMOOTHING     = 3'd3,
        REG_PEAK_DECAY    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [6:0]  valid_bits;
        logic [23:0] tick_period;
        logic [2:0]  frames_in_flight;
        logic [15:0] smoothing;
        logic [15:0] peak_decay;
    } t_cfg;

    // one classified sample handed from the front to the back
    typedef struct packed {
        logic [15:0] key;
        logic [5:0]  depth;
        logic [31:0] ns;
        logic [31:0] frame;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    typedef struct packed {
        logic [15:0] key;
        logic [47:0] avg;
        logic [47:0] peak;
        logic [31:0] last_frame;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[hdl/scope_timing_statistics.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_timing_statistics
// Per-region smoothed average and decaying peak of timed-region durations.
// ----------------------------------------------------------------------------
// The front takes a new sample only after pushing the last one on. It masks
// the ticks, converts them to ns with two 24x24 products and drops samples
// lacking a timestamp. The back then scans the region table through its RAM
// read port, one entry a cycle, over the whole table (less on an early hit),
// then runs five products through one 32x17 multiplier and writes back once
// its result register is free. A two-entry queue lets the front take the next
// sample while the back works, and the result register holds a finished
// result while the next one is computed.
module scope_timing_statistics #(
    parameter int TABLE_DEPTH   = scts_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_IN_FLIGHT = scts_pkg::MAX_IN_FLIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [scts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [15:0]                     i_region_key,
    input  logic [5:0]                      i_nest_depth,
    input  logic [63:0]                     i_start_tick,
    input  logic [63:0]                     i_stop_tick,
    input  logic                            i_start_ready,
    input  logic                            i_stop_ready,
    input  logic [31:0]                     i_frame_number,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [15:0]                     o_out_key,
    output logic [5:0]                      o_out_depth,
    output logic [31:0]                     o_sample_ns,
    output logic [31:0]                     o_average_ns,
    output logic [31:0]                     o_peak_ns,
    output logic                            o_status
);
    import scts_pkg::*;

    t_cfg             r_cfg;
    logic             w_fq_valid, w_fq_ready, w_qb_valid, w_qb_ready;
    t_job             w_fq_job, w_qb_job;
    logic [JOB_W-1:0] w_qb_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.valid_bits       <= 7'd64;
            r_cfg.tick_period      <= 24'd65536;
            r_cfg.frames_in_flight <= 3'd2;
            r_cfg.smoothing        <= 16'd3277;
            r_cfg.peak_decay       <= 16'd64881;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VALID_BITS:    r_cfg.valid_bits       <= i_cfg_data[6:0];
                REG_TICK_PERIOD:   r_cfg.tick_period      <= i_cfg_data[23:0];
                REG_FRAMES_FLIGHT: r_cfg.frames_in_flight <= i_cfg_data[2:0];
                REG_SMOOTHING:     r_cfg.smoothing        <= i_cfg_data[15:0];
                REG_PEAK_DECAY:    r_cfg.peak_decay       <= i_cfg_data[15:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    scts_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_region_key   (i_region_key),
        .i_nest_depth   (i_nest_depth),
        .i_start_tick   (i_start_tick),
        .i_stop_tick    (i_stop_tick),
        .i_start_ready  (i_start_ready),
        .i_stop_ready   (i_stop_ready),
        .i_frame_number (i_frame_number),
        .o_job_valid    (w_fq_valid),
        .i_job_ready    (w_fq_ready),
        .o_job          (w_fq_job)
    );

    scts_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_data  (w_fq_job),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_data   (w_qb_data)
    );

    assign w_qb_job = t_job'(w_qb_data);

    scts_back #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MAX_IN_FLIGHT (MAX_IN_FLIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_job_valid  (w_qb_valid),
        .o_job_ready  (w_qb_ready),
        .i_job        (w_qb_job),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_key    (o_out_key),
        .o_out_depth  (o_out_depth),
        .o_sample_ns  (o_sample_ns),
        .o_average_ns (o_average_ns),
        .o_peak_ns    (o_peak_ns),
        .o_status     (o_status)
    );

endmodule

[hdl/scts_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scts_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module scts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/scts_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scts_front
// Takes samples, drops those without both timestamps, converts to ns.
// ----------------------------------------------------------------------------
module scts_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  scts_pkg::t_cfg i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [15:0]    i_region_key,
    input  logic [5:0]     i_nest_depth,
    input  logic [63:0]    i_start_tick,
    input  logic [63:0]    i_stop_tick,
    input  logic           i_start_ready,
    input  logic           i_stop_ready,
    input  logic [31:0]    i_frame_number,
    output logic           o_job_valid,
    input  logic           i_job_ready,
    output scts_pkg::t_job o_job
);
    import scts_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE, F_DIFF, F_MUL_HI, F_MUL_LO, F_SUM, F_PUSH
    } t_state;

    t_state      r_state;
    logic [63:0] r_start, r_stop, r_ticks;
    logic [15:0] r_key;
    logic [5:0]  r_depth;
    logic [31:0] r_frame, r_ns;
    logic [47:0] r_prod;
    logic [55:0] r_acc;
    logic        r_zero, r_big;

    logic [63:0] w_mask, w_b, w_e;
    logic [56:0] w_sum;

    always_comb begin
        w_mask = (i_cfg.valid_bits >= 7'd64) ? {64{1'b1}}
                                             : ~({64{1'b1}} << i_cfg.valid_bits[5:0]);
        w_b    = r_start & w_mask;
        w_e    = r_stop & w_mask;
        w_sum  = 57'(r_acc) + 57'(r_prod[47:16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_in_valid && i_start_ready && i_stop_ready) begin
                        r_start <= i_start_tick;
                        r_stop  <= i_stop_tick;
                        r_key   <= i_region_key;
                        r_depth <= i_nest_depth;
                        r_frame <= i_frame_number;
                        r_state <= F_DIFF;
                    end
                end
                F_DIFF: begin
                    r_ticks <= (w_e >= w_b) ? (w_e - w_b) : 64'd0;
                    r_state <= F_MUL_HI;
                end
                F_MUL_HI: begin
                    r_zero  <= (i_cfg.tick_period == 24'd0);
                    r_big   <= (r_ticks[63:48] != 16'd0);
                    r_prod  <= 48'(r_ticks[47:24] * i_cfg.tick_period);
                    r_state <= F_MUL_LO;
                end
                F_MUL_LO: begin
                    r_acc   <= {r_prod, 8'd0};
                    r_prod  <= 48'(r_ticks[23:0] * i_cfg.tick_period);
                    r_state <= F_SUM;
                end
                F_SUM: begin
                    if (r_zero) begin
                        r_ns <= 32'd0;
                    end else if (r_big || (w_sum[56:32] != 25'd0)) begin
                        r_ns <= 32'hFFFF_FFFF;
                    end else begin
                        r_ns <= w_sum[31:0];
                    end
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);
    assign o_job.key   = r_key;
    assign o_job.depth = r_depth;
    assign o_job.ns    = r_ns;
    assign o_job.frame = r_frame;

endmodule

[hdl/scts_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scts_queue
// Two-entry register queue between the front and the back.
// ----------------------------------------------------------------------------
module scts_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             w_push, w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[hdl/scts_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scts_back
// Key search over the region table, average and peak update, result register.
// ----------------------------------------------------------------------------
module scts_back #(
    parameter int TABLE_DEPTH   = scts_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_IN_FLIGHT = scts_pkg::MAX_IN_FLIGHT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  scts_pkg::t_cfg i_cfg,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  scts_pkg::t_job i_job,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [15:0]    o_out_key,
    output logic [5:0]     o_out_depth,
    output logic [31:0]    o_sample_ns,
    output logic [31:0]    o_average_ns,
    output logic [31:0]    o_peak_ns,
    output logic           o_status
);
    import scts_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] { B_IDLE, B_SEARCH, B_MUL, B_WB } t_state;

    t_state           r_state;
    t_job             r_job;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [IW:0]      r_idx;
    logic             r_cmp_vld;
    logic [IW-1:0]    r_cmp_idx;
    logic             r_hit, r_free_found;
    logic [IW-1:0]    r_slot, r_free_idx;
    logic [47:0]      r_avg, r_peak;
    logic [31:0]      r_last;
    logic [2:0]       r_step;
    logic [48:0]      r_prod;
    logic [65:0]      r_acc, r_pacc;

    logic             r_out_valid;
    logic [15:0]      r_out_key;
    logic [5:0]       r_out_depth;
    logic [31:0]      r_sample_ns, r_average_ns, r_peak_ns;
    logic             r_status;

    t_entry           w_rd, w_wr;
    logic             w_we;
    logic [IW-1:0]    w_waddr;
    logic [31:0]      w_mul_a;
    logic [16:0]      w_mul_b, w_ws;
    logic [31:0]      w_gap, w_limit;
    logic             w_contig, w_full, w_out_free;
    logic [47:0]      w_x, w_decayed, w_new_avg, w_new_peak;
    logic [ENTRY_W-1:0] w_rdata;

    assign w_rd = t_entry'(w_rdata);

    scts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wr),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_rdata)
    );

    // shared multiplier operands, one partial product per step
    always_comb begin
        w_ws = 17'd65536 - {1'b0, i_cfg.smoothing};
        case (r_step)
            3'd0: begin w_mul_a = r_avg[31:0];             w_mul_b = w_ws; end
            3'd1: begin w_mul_a = {16'd0, r_avg[47:32]};   w_mul_b = w_ws; end
            3'd2: begin w_mul_a = r_job.ns;                w_mul_b = {1'b0, i_cfg.smoothing}; end
            3'd3: begin w_mul_a = r_peak[31:0];            w_mul_b = {1'b0, i_cfg.peak_decay}; end
            3'd4: begin w_mul_a = {16'd0, r_peak[47:32]};  w_mul_b = {1'b0, i_cfg.peak_decay}; end
            default: begin w_mul_a = 32'd0;                w_mul_b = 17'd0; end
        endcase
    end

    always_comb begin
        w_limit = ((i_cfg.frames_in_flight > 3'(MAX_IN_FLIGHT) && MAX_IN_FLIGHT < 8)
                   ? 32'(MAX_IN_FLIGHT) : 32'(i_cfg.frames_in_flight)) + 32'd1;
        w_gap      = r_job.frame - r_last;
        w_contig   = (w_gap <= w_limit);
        w_x        = {r_job.ns, 16'd0};
        w_decayed  = r_pacc[63:16];
        w_new_avg  = w_contig ? r_acc[63:16] : w_x;
        w_new_peak = (w_contig && (w_decayed > w_x)) ? w_decayed : w_x;
        w_full     = !r_hit && !r_free_found;
        w_out_free = !r_out_valid || i_out_ready;
        w_we       = (r_state == B_WB) && w_out_free && !w_full;
        w_waddr    = r_hit ? r_slot : r_free_idx;
        w_wr.key        = r_job.key;
        w_wr.avg        = w_new_avg;
        w_wr.peak       = w_new_peak;
        w_wr.last_frame = r_job.frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == B_WB) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_job        <= i_job;
                        r_idx        <= '0;
                        r_cmp_vld    <= 1'b0;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                        r_state      <= B_SEARCH;
                    end
                end
                B_SEARCH: begin
                    // read issue runs one entry ahead of the compare
                    if (r_idx != (IW+1)'(TABLE_DEPTH)) begin
                        r_idx     <= r_idx + (IW+1)'(1);
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= r_idx[IW-1:0];
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                    if (r_cmp_vld) begin
                        if (r_valid[r_cmp_idx] && (w_rd.key == r_job.key)) begin
                            r_hit   <= 1'b1;
                            r_slot  <= r_cmp_idx;
                            r_avg   <= w_rd.avg;
                            r_peak  <= w_rd.peak;
                            r_last  <= w_rd.last_frame;
                            r_step  <= 3'd0;
                            r_state <= B_MUL;
                        end else begin
                            if (!r_valid[r_cmp_idx] && !r_free_found) begin
                                r_free_found <= 1'b1;
                                r_free_idx   <= r_cmp_idx;
                            end
                            if (r_cmp_idx == IW'(TABLE_DEPTH - 1)) begin
                                // new key starts from zeroed statistics
                                r_avg   <= 48'd0;
                                r_peak  <= 48'd0;
                                r_last  <= 32'd0;
                                r_step  <= 3'd0;
                                r_state <= B_MUL;
                            end
                        end
                    end
                end
                B_MUL: begin
                    r_prod <= 49'(w_mul_a * w_mul_b);
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd1: r_acc  <= 66'(r_prod) + 66'd32768;
                        3'd2: r_acc  <= r_acc + (66'(r_prod) << 32);
                        3'd3: r_acc  <= r_acc + (66'(r_prod) << 16);
                        3'd4: r_pacc <= 66'(r_prod);
                        3'd5: begin
                            r_pacc  <= r_pacc + (66'(r_prod) << 32);
                            r_state <= B_WB;
                        end
                        default: r_acc <= r_acc;
                    endcase
                end
                B_WB: begin
                    if (w_out_free) begin
                        r_out_key    <= r_job.key;
                        r_out_depth  <= r_job.depth;
                        r_sample_ns  <= r_job.ns;
                        if (w_full) begin
                            r_average_ns <= r_job.ns;
                            r_peak_ns    <= r_job.ns;
                            r_status     <= 1'b1;
                        end else begin
                            r_average_ns <= w_new_avg[47:16];
                            r_peak_ns    <= w_new_peak[47:16];
                            r_status     <= 1'b0;
                            r_valid[w_waddr] <= 1'b1;
                        end
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_job_ready  = (r_state == B_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_key    = r_out_key;
    assign o_out_depth  = r_out_depth;
    assign o_sample_ns  = r_sample_ns;
    assign o_average_ns = r_average_ns;
    assign o_peak_ns    = r_peak_ns;
    assign o_status     = r_status;

endmodule

[tb/scope_timing_statistics_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_timing_statistics_test
// Self-checking bench for the scope timing statistics block. Samples go in
// through the input channel, and a model of the region table predicts each
// result: duration, smoothed average, decaying peak and table-full status.
// Directed cases come first, then register extremes, then random traffic with
// random idling. One stretch fills the block with its output stalled. The
// last stretch fills the region table.
// ----------------------------------------------------------------------------
module scope_timing_statistics_test;
    import scts_pkg::*;

    localparam int TBL_N      = 64;
    localparam int FLIGHT_MAX = 4;
    localparam int SETTLE     = 200;

    typedef struct {
        logic [15:0] key;
        logic [5:0]  depth;
        logic [63:0] t_begin;
        logic [63:0] t_end;
        logic        begin_ok;
        logic        end_ok;
        logic [31:0] frame;
    } t_sample;

    typedef struct {
        logic [15:0] key;
        logic [5:0]  depth;
        logic [31:0] ns;
        logic [31:0] avg;
        logic [31:0] peak;
        logic        status;
    } t_stats;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [15:0] i_region_key = '0;
    logic [5:0]  i_nest_depth = '0;
    logic [63:0] i_start_tick = '0;
    logic [63:0] i_stop_tick = '0;
    logic        i_start_ready = 1'b0;
    logic        i_stop_ready = 1'b0;
    logic [31:0] i_frame_number = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_out_key;
    logic [5:0]  o_out_depth;
    logic [31:0] o_sample_ns;
    logic [31:0] o_average_ns;
    logic [31:0] o_peak_ns;
    logic        o_status;

    scope_timing_statistics u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // model copy of registers and region table
    logic [6:0]  cfg_bits;
    logic [23:0] cfg_period;
    logic [2:0]  cfg_flight;
    logic [15:0] cfg_smooth;
    logic [15:0] cfg_decay;
    logic        tbl_used  [TBL_N];
    logic [15:0] tbl_key   [TBL_N];
    logic [63:0] tbl_avg   [TBL_N];
    logic [63:0] tbl_peak  [TBL_N];
    logic [31:0] tbl_frame [TBL_N];

    t_stats pending_stats[$];
    int     mismatches = 0;
    bit     no_gaps = 1'b0;
    int     stall_cycles = 0;
    logic [31:0] cur_frame;
    logic [15:0] key_pool[40];

    function automatic logic [31:0] ticks_to_ns(logic [63:0] ticks);
        logic [63:0] per, hi, lo, v;
        per = {40'd0, cfg_period};
        if (per == 0) return 32'd0;
        if (ticks[63:48] != 0) return 32'hFFFF_FFFF;
        hi = ticks >> 24;
        lo = {40'd0, ticks[23:0]};
        v = ((hi * per) << 8) + ((lo * per) >> 16);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic void update_stats(t_sample s);
        logic [63:0] mask, b, e, x, a, p, dec, sm, dc, lim;
        logic [31:0] ns, gap;
        t_stats r;
        int slot, free_slot;
        slot = -1;
        free_slot = -1;
        if (!s.begin_ok || !s.end_ok) return;
        if (cfg_bits >= 64) mask = '1;
        else if (cfg_bits == 0) mask = '0;
        else mask = (64'd1 << cfg_bits) - 64'd1;
        b = s.t_begin & mask;
        e = s.t_end & mask;
        ns = ticks_to_ns(e >= b ? e - b : 64'd0);
        x = {16'd0, ns, 16'd0};
        r.key = s.key;
        r.depth = s.depth;
        r.ns = ns;
        for (int i = 0; i < TBL_N; i++) begin
            if (tbl_used[i]) begin
                if (tbl_key[i] == s.key) begin
                    slot = i;
                    break;
                end
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (slot < 0 && free_slot < 0) begin
            r.avg = ns;
            r.peak = ns;
            r.status = 1'b1;
            pending_stats.insert(pending_stats.size(), r);
            return;
        end
        if (slot < 0) begin
            slot = free_slot;
            tbl_used[slot] = 1'b1;
            tbl_key[slot] = s.key;
            tbl_avg[slot] = '0;
            tbl_peak[slot] = '0;
            tbl_frame[slot] = '0;
        end
        lim = (cfg_flight > FLIGHT_MAX) ? FLIGHT_MAX : cfg_flight;
        lim = lim + 1;
        gap = s.frame - tbl_frame[slot];
        if ({32'd0, gap} <= lim) begin
            sm = {48'd0, cfg_smooth};
            dc = {48'd0, cfg_decay};
            a = (tbl_avg[slot] * (64'd65536 - sm) + x * sm + 64'd32768) >> 16;
            dec = (tbl_peak[slot] * dc) >> 16;
            p = (x > dec) ? x : dec;
        end else begin
            a = x;
            p = x;
        end
        tbl_avg[slot] = a;
        tbl_peak[slot] = p;
        tbl_frame[slot] = s.frame;
        r.avg = a[47:16];
        r.peak = p[47:16];
        r.status = 1'b0;
        pending_stats.insert(pending_stats.size(), r);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_stats exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result key=%h ns=%0d", o_out_key, o_sample_ns);
            end else begin
                exp_r = pending_stats.pop_front();
                if (o_out_key !== exp_r.key || o_out_depth !== exp_r.depth ||
                    o_sample_ns !== exp_r.ns || o_average_ns !== exp_r.avg ||
                    o_peak_ns !== exp_r.peak || o_status !== exp_r.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp key=%h d=%0d ns=%0d avg=%0d pk=%0d st=%0d %s",
                                 exp_r.key, exp_r.depth, exp_r.ns, exp_r.avg, exp_r.peak,
                                 exp_r.status, "");
                    if (mismatches <= 10)
                        $display("         got key=%h d=%0d ns=%0d avg=%0d pk=%0d st=%0d",
                                 o_out_key, o_out_depth, o_sample_ns, o_average_ns,
                                 o_peak_ns, o_status);
                end
            end
        end
    end

    // receiver: random stalls, plus a counted hold-off on request
    always @(negedge i_clk) begin
        if (stall_cycles > 0) begin
            i_out_ready <= 1'b0;
            stall_cycles <= stall_cycles - 1;
        end else begin
            i_out_ready <= no_gaps || ($urandom_range(99) >= 28);
        end
    end

    task automatic send_sample(t_sample s);
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(99) < 28) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_region_key   <= s.key;
        i_nest_depth   <= s.depth;
        i_start_tick   <= s.t_begin;
        i_stop_tick    <= s.t_end;
        i_start_ready  <= s.begin_ok;
        i_stop_ready   <= s.end_ok;
        i_frame_number <= s.frame;
        i_in_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        update_stats(s);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        // a dropped sample may still be in flight with nothing expected
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_VALID_BITS:    cfg_bits   = value[6:0];
            REG_TICK_PERIOD:   cfg_period = value[23:0];
            REG_FRAMES_FLIGHT: cfg_flight = value[2:0];
            REG_SMOOTHING:     cfg_smooth = value[15:0];
            REG_PEAK_DECAY:    cfg_decay  = value[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [6:0] vb, logic [23:0] per, logic [2:0] fl,
                             logic [15:0] sm, logic [15:0] dc);
        wait_idle();
        write_reg(REG_VALID_BITS, {17'd0, vb});
        write_reg(REG_TICK_PERIOD, per);
        write_reg(REG_FRAMES_FLIGHT, {21'd0, fl});
        write_reg(REG_SMOOTHING, {8'd0, sm});
        write_reg(REG_PEAK_DECAY, {8'd0, dc});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_sample mk(logic [15:0] key, logic [63:0] t0, logic [63:0] t1,
                                   logic [31:0] frame);
        t_sample s;
        s.key = key;
        s.depth = 6'($urandom);
        s.t_begin = t0;
        s.t_end = t1;
        s.begin_ok = 1'b1;
        s.end_ok = 1'b1;
        s.frame = frame;
        return s;
    endfunction

    function automatic t_sample random_sample(logic [15:0] key);
        t_sample s;
        logic [63:0] t0, d;
        t0 = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       d = {$urandom, $urandom};
            1:       d = -64'($urandom_range(1000));
            2, 3:    d = {32'd0, $urandom};
            default: d = 64'($urandom_range(20000));
        endcase
        // frames mostly advance slowly, now and then they jump
        if ($urandom_range(19) == 0) cur_frame = $urandom;
        else cur_frame = cur_frame + $urandom_range(3);
        s = mk(key, t0, t0 + d, cur_frame);
        s.begin_ok = ($urandom_range(24) != 0);
        s.end_ok = ($urandom_range(24) != 0);
        return s;
    endfunction

    task automatic test_directed();
        t_sample s;
        s = mk(16'h0000, 64'd10, 64'd20, 32'd5);
        s.begin_ok = 1'b0;
        send_sample(s);
        s.begin_ok = 1'b1;
        s.end_ok = 1'b0;
        send_sample(s);
        s.begin_ok = 1'b0;
        send_sample(s);
        s = mk(16'h0000, 64'd100, 64'd1100, 32'd1);
        s.depth = 6'd0;
        send_sample(s);
        s = mk(16'h0000, 64'd100, 64'd5100, 32'd2);
        s.depth = 6'd63;
        send_sample(s);
        send_sample(mk(16'h0000, 64'd500, 64'd500, 32'd5));
        send_sample(mk(16'h0000, 64'd900, 64'd100, 32'd9));
        send_sample(mk(16'h0000, 64'd0, 64'd12345, 32'd13));
        send_sample(mk(16'hFFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFE));
        send_sample(mk(16'hFFFF, 64'd7, 64'h0000_FFFF_FFFF_FFFF, 32'h0000_0001));
        send_sample(mk(16'hFFFF, 64'd7, 64'h0001_0000_0000_0000, 32'h0000_0003));
        send_sample(mk(16'hFFFF, 64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0400,
                       32'h0000_0004));
        send_sample(mk(16'h1234, 64'd1, 64'd4000, 32'd0));
        send_sample(mk(16'h1234, 64'd1, 64'd9000, 32'd0));
    endtask

    task automatic test_register_extremes();
        configure(7'd0, 24'd65536, 3'd0, 16'd0, 16'd0);
        send_sample(mk(16'h0101, 64'd10, 64'd90000, 32'd0));
        send_sample(mk(16'h0101, 64'd10, 64'd90000, 32'd1));
        configure(7'd100, 24'hFF_FFFF, 3'd7, 16'hFFFF, 16'hFFFF);
        send_sample(mk(16'h0202, 64'd0, 64'd300, 32'd4));
        send_sample(mk(16'h0202, 64'd0, 64'd100, 32'd9));
        send_sample(mk(16'h0202, 64'd0, 64'hFFFF_FFFF, 32'd15));
        send_sample(mk(16'h0202, 64'd0, 64'd50, 32'd16));
        configure(7'd1, 24'd0, 3'd4, 16'd3277, 16'd64881);
        send_sample(mk(16'h0303, 64'd0, 64'd1, 32'd0));
        configure(7'd1, 24'd1, 3'd1, 16'd32768, 16'd32768);
        send_sample(mk(16'h0303, 64'd0, 64'd1, 32'd2));
        send_sample(mk(16'h0303, 64'd2, 64'd5, 32'd3));
        configure(7'd64, 24'd65536, 3'd2, 16'd3277, 16'd64881);
    endtask

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++)
            send_sample(random_sample(key_pool[$urandom_range(39)]));
    endtask

    task automatic test_random();
        foreach (key_pool[k]) key_pool[k] = 16'($urandom);
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        cur_frame = 32'hFFFF_FF00;
        no_gaps = 1'b1;
        random_phase(150);
        no_gaps = 1'b0;
        random_phase(250);
        configure(7'd40, 24'd1000, 3'd3, 16'd20000, 16'd50000);
        random_phase(350);
        configure(7'd64, 24'd2_000_000, 3'd1, 16'd65535, 16'd65535);
        random_phase(300);
        configure(7'd20, 24'd123, 3'd6, 16'd1, 16'd0);
        random_phase(250);
        configure(7'd64, 24'd65536, 3'd2, 16'd3277, 16'd64881);
    endtask

    task automatic test_backpressure();
        // output held off while the sender keeps offering samples
        @(negedge i_clk);
        stall_cycles = 1500;
        no_gaps = 1'b1;
        for (int n = 0; n < 20; n++) send_sample(random_sample(key_pool[n]));
        no_gaps = 1'b0;
        wait_idle();
    endtask

    task automatic test_table_full();
        t_sample s;
        int used;
        used = 0;
        foreach (tbl_used[i]) if (tbl_used[i]) used++;
        // new keys until every entry is taken and well beyond
        for (int n = 0; n < TBL_N - used + 30; n++) begin
            s = random_sample(16'($urandom));
            s.begin_ok = 1'b1;
            s.end_ok = 1'b1;
            send_sample(s);
        end
        for (int n = 0; n < 300; n++) begin
            if ($urandom_range(1)) send_sample(random_sample(16'($urandom)));
            else send_sample(random_sample(key_pool[$urandom_range(39)]));
        end
        wait_idle();
    endtask

    initial begin
        #20_000_000;
        $display("scope_timing_statistics verification failed");
        $finish;
    end

    initial begin
        cfg_bits = 7'd64;
        cfg_period = 24'd65536;
        cfg_flight = 3'd2;
        cfg_smooth = 16'd3277;
        cfg_decay = 16'd64881;
        foreach (tbl_used[i]) tbl_used[i] = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_register_extremes();
        test_random();
        test_backpressure();
        test_table_full();
        if (mismatches == 0 && pending_stats.size() == 0) begin
            $display("scope_timing_statistics verification clean");
        end else begin
            $display("scope_timing_statistics verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/scts_pkg.sv
hdl/scts_ram.sv
hdl/scts_front.sv
hdl/scts_queue.sv
hdl/scts_back.sv
hdl/scope_timing_statistics.sv
tb/scope_timing_statistics_test.sv
